>>> rtl/core/dqvr_pkg.sv
`timescale 1ns / 1ps

package dqvr_pkg;

    localparam int OP_W     = 3;
    localparam int READ_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE     = 3'd4,
        OP_PEEK_FRONT = 3'd5,
        OP_PEEK_BACK  = 3'd6,
        OP_NOP        = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        SH_HOLD,
        SH_PUSH_FRONT,
        SH_PUSH_BACK,
        SH_POP_FRONT,
        SH_POP_BACK
    } shift_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } ctl_state_t;

    typedef struct packed {
        shift_t shift;
        logic   remove;
    } cell_ctrl_t;

    typedef struct packed {
        logic active;
        logic found;
    } tok_t;

endpackage

>>> rtl/core/dqvr_cell.sv
`timescale 1ns / 1ps

module dqvr_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dqvr_pkg::cell_ctrl_t      ctrl,
    input  logic [VALUE_WIDTH-1:0]    push_value,
    input  logic [VALUE_WIDTH-1:0]    key,
    input  logic [VALUE_WIDTH-1:0]    left_data,
    input  logic                      left_valid,
    input  logic [VALUE_WIDTH-1:0]    right_data,
    input  logic                      right_valid,
    input  dqvr_pkg::tok_t            tok_in,
    input  logic [VALUE_WIDTH-1:0]    rd_in,
    output logic [VALUE_WIDTH-1:0]    data,
    output logic                      valid,
    output dqvr_pkg::tok_t            tok_out,
    output logic [VALUE_WIDTH-1:0]    rd_out
);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;
    logic                   valid_reg;
    logic                   valid_next;
    dqvr_pkg::tok_t         tok_reg;
    logic [VALUE_WIDTH-1:0] rd_reg;
    logic                   hit;
    logic                   close_gap;

    assign hit = tok_reg.active && ctrl.remove && valid_reg && !tok_reg.found
                 && (data_reg == key);
    assign close_gap = tok_reg.active && ctrl.remove && (tok_reg.found || hit);

    assign tok_out.active = tok_reg.active;
    assign tok_out.found  = tok_reg.found || hit;

    // pick up the back entry as the token passes it
    assign rd_out = (tok_reg.active && !ctrl.remove && valid_reg && !right_valid)
                    ? data_reg : rd_reg;

    assign data  = data_reg;
    assign valid = valid_reg;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctrl.shift)
            dqvr_pkg::SH_PUSH_FRONT:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            dqvr_pkg::SH_PUSH_BACK:
            begin
                if (!valid_reg && left_valid)
                begin
                    data_next  = push_value;
                    valid_next = 1'b1;
                end
            end
            dqvr_pkg::SH_POP_FRONT:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            dqvr_pkg::SH_POP_BACK:
            begin
                if (valid_reg && !right_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                if (close_gap)
                begin
                    data_next  = right_data;
                    valid_next = right_valid;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_in;
    end

endmodule

>>> rtl/core/dqvr_ctrl.sv
`timescale 1ns / 1ps

module dqvr_ctrl #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [dqvr_pkg::OP_W-1:0]           op,
    input  logic signed [dqvr_pkg::READ_W-1:0]  value,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic signed [dqvr_pkg::READ_W-1:0]  read_value,
    output logic [dqvr_pkg::STATUS_W-1:0]       status,
    output logic [dqvr_pkg::COUNT_W-1:0]        count,
    output logic                                is_empty,
    input  logic [VALUE_WIDTH-1:0]              front_data,
    input  dqvr_pkg::tok_t                      tok_last,
    input  logic [VALUE_WIDTH-1:0]              rd_last,
    output dqvr_pkg::cell_ctrl_t                ctrl,
    output logic [VALUE_WIDTH-1:0]              push_value,
    output logic [VALUE_WIDTH-1:0]              key,
    output dqvr_pkg::tok_t                      tok_start
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);
    localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

    dqvr_pkg::ctl_state_t              state_reg;
    dqvr_pkg::ctl_state_t              state_next;
    logic [OCC_W-1:0]                  occ_reg;
    logic [OCC_W-1:0]                  occ_next;
    logic                              remove_reg;
    logic                              remove_next;
    logic [VALUE_WIDTH-1:0]            key_reg;
    logic [VALUE_WIDTH-1:0]            key_next;
    logic                              res_valid_reg;
    logic                              res_valid_next;
    logic signed [dqvr_pkg::READ_W-1:0] read_value_reg;
    logic signed [dqvr_pkg::READ_W-1:0] read_value_next;
    dqvr_pkg::status_t                 status_reg;
    dqvr_pkg::status_t                 status_next;
    logic                              accept;
    logic                              load;
    logic                              q_empty;
    logic                              q_full;
    dqvr_pkg::op_t                     op_cmd;
    logic [VALUE_WIDTH-1:0]            value_in;

    assign op_cmd   = dqvr_pkg::op_t'(op);
    assign value_in = VALUE_WIDTH'(value);
    assign q_empty  = (occ_reg == '0);
    assign q_full   = (occ_reg == OCC_FULL);

    assign cmd_ready = (state_reg == dqvr_pkg::ST_IDLE) && (!res_valid_reg || res_ready);
    assign accept    = cmd_valid && cmd_ready;

    assign push_value = value_in;
    assign key        = key_reg;

    assign res_valid  = res_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = dqvr_pkg::COUNT_W'(occ_reg);
    assign is_empty   = q_empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dqvr_pkg::ST_IDLE:
            begin
                if (accept && (op_cmd == dqvr_pkg::OP_REMOVE
                               || (op_cmd == dqvr_pkg::OP_PEEK_BACK && !q_empty)))
                begin
                    state_next = dqvr_pkg::ST_SWEEP;
                end
            end
            dqvr_pkg::ST_SWEEP:
            begin
                if (tok_last.active)
                begin
                    state_next = dqvr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dqvr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.shift       = dqvr_pkg::SH_HOLD;
        ctrl.remove      = remove_reg;
        tok_start.active = 1'b0;
        tok_start.found  = 1'b0;
        load             = 1'b0;
        status_next      = dqvr_pkg::ST_OK;
        read_value_next  = '0;
        occ_next         = occ_reg;
        remove_next      = remove_reg;
        key_next         = key_reg;
        unique case (state_reg)
            dqvr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_cmd) inside
                        dqvr_pkg::OP_PUSH_FRONT, dqvr_pkg::OP_PUSH_BACK:
                        begin
                            load = 1'b1;
                            if (q_full)
                            begin
                                status_next = dqvr_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.shift = (op_cmd == dqvr_pkg::OP_PUSH_FRONT)
                                             ? dqvr_pkg::SH_PUSH_FRONT
                                             : dqvr_pkg::SH_PUSH_BACK;
                                occ_next   = occ_reg + OCC_ONE;
                            end
                        end
                        dqvr_pkg::OP_POP_FRONT, dqvr_pkg::OP_POP_BACK:
                        begin
                            load = 1'b1;
                            if (q_empty)
                            begin
                                status_next = dqvr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.shift = (op_cmd == dqvr_pkg::OP_POP_FRONT)
                                             ? dqvr_pkg::SH_POP_FRONT
                                             : dqvr_pkg::SH_POP_BACK;
                                occ_next   = occ_reg - OCC_ONE;
                            end
                        end
                        dqvr_pkg::OP_REMOVE:
                        begin
                            tok_start.active = 1'b1;
                            remove_next      = 1'b1;
                            key_next         = value_in;
                        end
                        dqvr_pkg::OP_PEEK_FRONT:
                        begin
                            load = 1'b1;
                            if (q_empty)
                            begin
                                status_next = dqvr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                read_value_next = dqvr_pkg::READ_W'($signed(front_data));
                            end
                        end
                        dqvr_pkg::OP_PEEK_BACK:
                        begin
                            if (q_empty)
                            begin
                                load        = 1'b1;
                                status_next = dqvr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                tok_start.active = 1'b1;
                                remove_next      = 1'b0;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            dqvr_pkg::ST_SWEEP:
            begin
                if (tok_last.active)
                begin
                    load = 1'b1;
                    if (remove_reg)
                    begin
                        if (tok_last.found)
                        begin
                            occ_next = occ_reg - OCC_ONE;
                        end
                        else
                        begin
                            status_next = dqvr_pkg::ST_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        read_value_next = dqvr_pkg::READ_W'($signed(rd_last));
                    end
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqvr_pkg::ST_IDLE;
            occ_reg       <= '0;
            res_valid_reg <= 1'b0;
            remove_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            res_valid_reg <= res_valid_next;
            remove_reg    <= remove_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (load)
        begin
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
        end
    end

endmodule

>>> rtl/core/deque_with_value_removal_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// command   cmd_valid / cmd_ready    op, value
// result    res_valid / res_ready    read_value, status, count, is_empty
//
// Push, pop, peek front, the unused code, a refused push and a pop or peek on
// an empty queue show the result in the cycle after the transfer.
// Remove (found or not, empty queue included) and peek back on a non-empty queue
// pass a token down the cell row, one cell a cycle; the result is registered once
// the token leaves the last cell.
// A new command is taken only when no token is in the row and the previous result
// has been or is being taken.
// Reset clears occupancy and the result channel; entries need no clearing.

module deque_with_value_removal_unit #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [dqvr_pkg::OP_W-1:0]           op,
    input  logic signed [dqvr_pkg::READ_W-1:0]  value,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic signed [dqvr_pkg::READ_W-1:0]  read_value,
    output logic [dqvr_pkg::STATUS_W-1:0]       status,
    output logic [dqvr_pkg::COUNT_W-1:0]        count,
    output logic                                is_empty
);

    dqvr_pkg::cell_ctrl_t   ctrl;
    logic [VALUE_WIDTH-1:0] push_value;
    logic [VALUE_WIDTH-1:0] key;
    dqvr_pkg::tok_t         tok_start;

    logic [VALUE_WIDTH-1:0] cell_data  [CAPACITY];
    logic                   cell_valid [CAPACITY];
    dqvr_pkg::tok_t         cell_tok   [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_rd    [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_data;
        logic                   left_valid;
        logic [VALUE_WIDTH-1:0] right_data;
        logic                   right_valid;
        dqvr_pkg::tok_t         tok_in;
        logic [VALUE_WIDTH-1:0] rd_in;

        if (i == 0)
        begin : g_head
            assign left_data  = push_value;
            assign left_valid = 1'b1;
            assign tok_in     = tok_start;
            assign rd_in      = '0;
        end
        else
        begin : g_body
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
            assign tok_in     = cell_tok[i-1];
            assign rd_in      = cell_rd[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
        end

        dqvr_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .push_value  (push_value),
            .key         (key),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .tok_in      (tok_in),
            .rd_in       (rd_in),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .tok_out     (cell_tok[i]),
            .rd_out      (cell_rd[i])
        );
    end

    dqvr_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .op         (op),
        .value      (value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .read_value (read_value),
        .status     (status),
        .count      (count),
        .is_empty   (is_empty),
        .front_data (cell_data[0]),
        .tok_last   (cell_tok[CAPACITY-1]),
        .rd_last    (cell_rd[CAPACITY-1]),
        .ctrl       (ctrl),
        .push_value (push_value),
        .key        (key),
        .tok_start  (tok_start)
    );

endmodule

>>> dv/deque_result_checker.sv
`timescale 1ns / 1ps

module deque_result_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  logic                                cmd_ready,
    input  logic [dqvr_pkg::OP_W-1:0]           op,
    input  logic signed [dqvr_pkg::READ_W-1:0]  value,
    input  logic                                res_valid,
    input  logic                                res_ready,
    input  logic signed [dqvr_pkg::READ_W-1:0]  read_value,
    input  logic [dqvr_pkg::STATUS_W-1:0]       status,
    input  logic [dqvr_pkg::COUNT_W-1:0]        count,
    input  logic                                is_empty,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  results_seen,
    output int                                  full_hits,
    output int                                  empty_hits,
    output int                                  missing_hits
);

    typedef struct packed {
        logic signed [dqvr_pkg::READ_W-1:0] read_value;
        dqvr_pkg::status_t                  status;
        logic [dqvr_pkg::COUNT_W-1:0]       count;
        logic                               is_empty;
    } deque_result_t;

    logic signed [dqvr_pkg::READ_W-1:0] mirror_cells [CAPACITY];
    int                                 mirror_fill;
    deque_result_t                      expected_results [$];

    initial
    begin
        mirror_fill  = 0;
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        full_hits    = 0;
        empty_hits   = 0;
        missing_hits = 0;
    end

    task automatic flag_mismatch(input string what);
        $display("checker: %0t %s", $time, what);
        fail_count++;
    endtask

    function automatic deque_result_t apply_command(
        input dqvr_pkg::op_t                      cmd,
        input logic signed [dqvr_pkg::READ_W-1:0] v);
        deque_result_t r;
        int            i;
        int            hit;
        r.read_value = '0;
        r.status     = dqvr_pkg::ST_OK;
        hit          = -1;
        case (cmd) inside
            dqvr_pkg::OP_PUSH_FRONT, dqvr_pkg::OP_PUSH_BACK:
            begin
                if (mirror_fill >= CAPACITY)
                begin
                    r.status = dqvr_pkg::ST_FULL;
                    full_hits++;
                end
                else if (cmd == dqvr_pkg::OP_PUSH_FRONT)
                begin
                    for (i = mirror_fill; i > 0; i--)
                        mirror_cells[i] = mirror_cells[i-1];
                    mirror_cells[0] = v;
                    mirror_fill++;
                end
                else
                begin
                    mirror_cells[mirror_fill] = v;
                    mirror_fill++;
                end
            end
            dqvr_pkg::OP_POP_FRONT, dqvr_pkg::OP_POP_BACK:
            begin
                if (mirror_fill == 0)
                begin
                    r.status = dqvr_pkg::ST_EMPTY;
                    empty_hits++;
                end
                else
                begin
                    if (cmd == dqvr_pkg::OP_POP_FRONT)
                        for (i = 0; i < mirror_fill - 1; i++)
                            mirror_cells[i] = mirror_cells[i+1];
                    mirror_fill--;
                end
            end
            dqvr_pkg::OP_REMOVE:
            begin
                for (i = 0; i < mirror_fill; i++)
                    if (hit < 0 && mirror_cells[i] == v)
                        hit = i;
                if (hit < 0)
                begin
                    r.status = dqvr_pkg::ST_NOT_FOUND;
                    missing_hits++;
                end
                else
                begin
                    // close the gap left by the first match
                    for (i = hit; i < mirror_fill - 1; i++)
                        mirror_cells[i] = mirror_cells[i+1];
                    mirror_fill--;
                end
            end
            dqvr_pkg::OP_PEEK_FRONT, dqvr_pkg::OP_PEEK_BACK:
            begin
                if (mirror_fill == 0)
                begin
                    r.status = dqvr_pkg::ST_EMPTY;
                    empty_hits++;
                end
                else if (cmd == dqvr_pkg::OP_PEEK_FRONT)
                    r.read_value = mirror_cells[0];
                else
                    r.read_value = mirror_cells[mirror_fill-1];
            end
            default:
            begin
            end
        endcase
        r.count    = mirror_fill[dqvr_pkg::COUNT_W-1:0];
        r.is_empty = (mirror_fill == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t exp_r;
        if (!rst_n)
        begin
            mirror_fill = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            // compare the result transfer before queueing a new command
            if (res_valid === 1'b1 && res_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    flag_mismatch("result transfer with no command outstanding");
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (read_value !== exp_r.read_value)
                        flag_mismatch($sformatf("read_value %h, expected %h",
                                                read_value, exp_r.read_value));
                    if (status !== exp_r.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                status, exp_r.status));
                    if (count !== exp_r.count)
                        flag_mismatch($sformatf("count %0d, expected %0d",
                                                count, exp_r.count));
                    if (is_empty !== exp_r.is_empty)
                        flag_mismatch($sformatf("is_empty %b, expected %b",
                                                is_empty, exp_r.is_empty));
                end
            end
            if (cmd_valid && cmd_ready === 1'b1)
                expected_results.push_back(apply_command(dqvr_pkg::op_t'(op), value));
            pending = expected_results.size();
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY     = 16;
    localparam int HALF_PERIOD  = 5;
    localparam int LONG_HOLD    = 80;
    localparam int SETTLE_TICKS = CAPACITY + 24;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 100;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               cmd_valid = 1'b0;
    logic                               res_ready = 1'b0;
    logic [dqvr_pkg::OP_W-1:0]          op        = '0;
    logic signed [dqvr_pkg::READ_W-1:0] value     = '0;
    logic                               cmd_ready;
    logic                               res_valid;
    logic signed [dqvr_pkg::READ_W-1:0] read_value;
    logic [dqvr_pkg::STATUS_W-1:0]      status;
    logic [dqvr_pkg::COUNT_W-1:0]       count;
    logic                               is_empty;

    int   fail_count;
    int   pending;
    int   results_seen;
    int   full_hits;
    int   empty_hits;
    int   missing_hits;
    int   commands_sent = 0;
    logic long_hold_due = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    deque_with_value_removal_unit #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (dqvr_pkg::READ_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .op         (op),
        .value      (value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .read_value (read_value),
        .status     (status),
        .count      (count),
        .is_empty   (is_empty)
    );

    deque_result_checker #(
        .CAPACITY (CAPACITY)
    ) result_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .op           (op),
        .value        (value),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .read_value   (read_value),
        .status       (status),
        .count        (count),
        .is_empty     (is_empty),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .full_hits    (full_hits),
        .empty_hits   (empty_hits),
        .missing_hits (missing_hits)
    );

    task automatic send_command(input dqvr_pkg::op_t cmd,
                                input logic signed [dqvr_pkg::READ_W-1:0] v);
        @(negedge clk);
        cmd_valid <= 1'b1;
        op        <= cmd;
        value     <= v;
        do
            @(posedge clk);
        while (cmd_ready !== 1'b1);
        commands_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        cmd_valid <= 1'b0;
        repeat (cycles - 1) @(posedge clk);
    endtask

    task automatic drain_results;
        @(negedge clk);
        cmd_valid <= 1'b0;
        wait (pending == 0);
    endtask

    initial
    begin : receiver
        int mode;
        int span;
        int hold_left;
        mode      = 0;
        span      = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 40);
            end
            span--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= $urandom_range(0, 1);
                    2:       res_ready <= ($urandom_range(0, 4) != 0);
                    default: res_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        int                                 push_w [PHASES];
        int                                 pop_w  [PHASES];
        int                                 rem_w  [PHASES];
        int                                 peek_w [PHASES];
        int                                 phase;
        int                                 phase_sent;
        int                                 burst;
        int                                 gap;
        int                                 pick;
        dqvr_pkg::op_t                      cmd;
        logic signed [dqvr_pkg::READ_W-1:0] v;

        push_w = '{70, 20, 40, 60, 30, 45};
        pop_w  = '{10, 60, 30, 15, 30, 25};
        rem_w  = '{10, 10, 20, 15, 25, 15};
        peek_w = '{10, 10, 10, 10, 15, 15};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_command(dqvr_pkg::OP_POP_FRONT, 32'sd0);
        send_command(dqvr_pkg::OP_POP_BACK, 32'sd0);
        send_command(dqvr_pkg::OP_PEEK_FRONT, 32'sd0);
        send_command(dqvr_pkg::OP_PEEK_BACK, 32'sd0);
        send_command(dqvr_pkg::OP_REMOVE, 32'sd0);
        send_command(dqvr_pkg::OP_NOP, $urandom);
        send_command(dqvr_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_command(dqvr_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_command(dqvr_pkg::OP_PUSH_BACK, 32'sd0);
        send_command(dqvr_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_command(dqvr_pkg::OP_PEEK_FRONT, 32'sd0);
        send_command(dqvr_pkg::OP_PEEK_BACK, 32'sd0);
        send_command(dqvr_pkg::OP_REMOVE, 32'sd12345);
        send_command(dqvr_pkg::OP_REMOVE, 32'hFFFF_FFFF);
        send_command(dqvr_pkg::OP_REMOVE, 32'h8000_0000);
        // duplicate value: only the one nearest the front goes
        send_command(dqvr_pkg::OP_PUSH_BACK, 32'sd9);
        send_command(dqvr_pkg::OP_PUSH_FRONT, 32'sd9);
        send_command(dqvr_pkg::OP_REMOVE, 32'sd9);
        send_command(dqvr_pkg::OP_PEEK_FRONT, 32'sd0);
        send_command(dqvr_pkg::OP_PEEK_BACK, 32'sd0);
        send_command(dqvr_pkg::OP_POP_FRONT, 32'sd0);
        send_command(dqvr_pkg::OP_POP_BACK, 32'sd0);
        send_command(dqvr_pkg::OP_POP_FRONT, 32'sd0);
        drain_results();

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 2)
                long_hold_due = 1'b1;
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 16);
                repeat (burst)
                begin
                    pick = $urandom_range(0, push_w[phase] + pop_w[phase] + rem_w[phase]
                                             + peek_w[phase] + 1);
                    if (pick < push_w[phase])
                        cmd = $urandom_range(0, 1) ? dqvr_pkg::OP_PUSH_BACK
                                                   : dqvr_pkg::OP_PUSH_FRONT;
                    else if (pick < push_w[phase] + pop_w[phase])
                        cmd = $urandom_range(0, 1) ? dqvr_pkg::OP_POP_BACK
                                                   : dqvr_pkg::OP_POP_FRONT;
                    else if (pick < push_w[phase] + pop_w[phase] + rem_w[phase])
                        cmd = dqvr_pkg::OP_REMOVE;
                    else if (pick < push_w[phase] + pop_w[phase] + rem_w[phase]
                                    + peek_w[phase])
                        cmd = $urandom_range(0, 1) ? dqvr_pkg::OP_PEEK_BACK
                                                   : dqvr_pkg::OP_PEEK_FRONT;
                    else
                        cmd = dqvr_pkg::OP_NOP;
                    case ($urandom_range(0, 7)) inside
                        [0:3]:   v = $signed($urandom_range(0, 5)) - 32'sd2;
                        4:       v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                        default: v = $urandom;
                    endcase
                    send_command(cmd, v);
                    phase_sent++;
                end
                gap = $urandom_range(0, 4);
                if (gap > 0)
                    idle_sender(gap);
            end
            drain_results();
        end

        repeat (SETTLE_TICKS) @(posedge clk);

        $display("run: %0d commands sent, %0d results checked", commands_sent, results_seen);
        $display("run: %0d pushes refused when full, %0d pops or peeks on empty, %0d removes missed",
                 full_hits, empty_hits, missing_hits);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/core/dqvr_pkg.sv
rtl/core/dqvr_cell.sv
rtl/core/dqvr_ctrl.sv
rtl/core/deque_with_value_removal_unit.sv
dv/deque_result_checker.sv
dv/testbench.sv
